[rtl/iss_pkg.sv]
// Shared types and constants for the indexed sequential search block.
// No dependencies; used by iss_ctrl, iss_dp and indexed_sequential_search.
`default_nettype none

package iss_pkg;

  // Table depth is tied to the 7-bit position field.
  localparam int TABLE_LENGTH = 128;
  localparam int POS_W        = 7;
  // Scan pointer and used length: wide enough for TABLE_LENGTH plus one stride.
  localparam int PTR_W        = 8;
  localparam int KIND_W       = 2;
  localparam int KEY_W        = 16;

  localparam int DEF_VALUE_BITS    = 16;
  localparam int DEF_INDEX_STRIDE  = 8;
  localparam int DEF_INDEX_ENTRIES = 16;

  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;       // take the input item
    logic walk_adv;    // index entry qualifies, step to the next one
    logic scan_begin;  // load scan pointer from the chosen block
    logic scan_adv;    // check one table entry, step forward
    logic finish;      // write the result register, retire the item
  } cmd_t;

  typedef struct packed {
    logic new_lookup;  // item at the input is a search or remove
    logic walk_go;     // current index entry is in range and not above key
    logic have_blk;    // some index entry qualified
    logic scan_go;     // current table entry keeps the scan going
    logic out_free;    // result register can take a new result
  } status_t;

endpackage

`default_nettype wire

[rtl/indexed_sequential_search.sv]
// Top level of the indexed sequential search block.
// Depends on iss_pkg, iss_ctrl and iss_dp.
//
// Usage:
//   Input channel (in_valid/in_ready): in_kind selects load (0), search (1)
//   or remove (2); in_position is the table slot of a load; in_value is the
//   loaded value or the key. Kind 3 gives a not-found result.
//   Result channel (out_valid/out_ready): one item per input item, in order.
//   out_found is 1 on a load, or on a search/remove hit; out_found_position
//   is the loaded slot or the last live matching slot, 0 on a miss.
//   Config port: cfg_we writes cfg_wdata into the used-length register at
//   once; write it only while the block is idle.
// Operation:
//   One item at a time. A load is accepted, then retired. A search or
//   remove is accepted, walks the index one entry per step, then scans
//   the table one entry per step from the chosen block onward, then
//   retires. Index and table memories each deliver one word per cycle;
//   that sets the pace of the walk and the scan.
// Reset (rst_n, synchronous): live marks clear, used length returns to 128,
//   result register empties. Table and index contents are not cleared.
// Stall: a finished result waits in the output register; the next item is
//   accepted meanwhile and its result holds in the retire step until free.
`default_nettype none

module indexed_sequential_search #(
  parameter int VALUE_BITS    = iss_pkg::DEF_VALUE_BITS,
  parameter int INDEX_STRIDE  = iss_pkg::DEF_INDEX_STRIDE,
  parameter int INDEX_ENTRIES = iss_pkg::DEF_INDEX_ENTRIES
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [iss_pkg::KIND_W-1:0] in_kind,
  input  wire logic [iss_pkg::POS_W-1:0]  in_position,
  input  wire logic [iss_pkg::KEY_W-1:0]  in_value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_found,
  output logic [iss_pkg::POS_W-1:0]       out_found_position,
  input  wire logic                       cfg_we,
  input  wire logic [iss_pkg::PTR_W-1:0]  cfg_wdata
);

  iss_pkg::cmd_t    cmd;
  iss_pkg::status_t st;

  // Sequencer: decides each cycle whether to walk, scan or retire.
  iss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Storage, pointers, compares and the result register.
  iss_dp #(
    .VALUE_BITS    (VALUE_BITS),
    .INDEX_STRIDE  (INDEX_STRIDE),
    .INDEX_ENTRIES (INDEX_ENTRIES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_kind            (in_kind),
    .in_position        (in_position),
    .in_value           (in_value),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_found          (out_found),
    .out_found_position (out_found_position)
  );

endmodule

`default_nettype wire

[rtl/iss_ctrl.sv]
// Sequencer for the indexed sequential search: accept, index walk, scan, retire.
// Depends on iss_pkg (state_t, cmd_t, status_t).
`default_nettype none

module iss_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire iss_pkg::status_t st,
  output iss_pkg::cmd_t        cmd
);

  iss_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      iss_pkg::ST_IDLE: begin
        // hold off the input while reset is applied
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.start = 1'b1;
          state_nxt = st.new_lookup ? iss_pkg::ST_WALK : iss_pkg::ST_DONE;
        end
      end
      iss_pkg::ST_WALK: begin
        if (st.walk_go) begin
          cmd.walk_adv = 1'b1;
        end else if (st.have_blk) begin
          cmd.scan_begin = 1'b1;
          state_nxt      = iss_pkg::ST_SCAN;
        end else begin
          state_nxt = iss_pkg::ST_DONE;
        end
      end
      iss_pkg::ST_SCAN: begin
        if (st.scan_go) begin
          cmd.scan_adv = 1'b1;
        end else begin
          state_nxt = iss_pkg::ST_DONE;
        end
      end
      iss_pkg::ST_DONE: begin
        // hold until the result register frees up
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = iss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = iss_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/iss_dp.sv]
// Datapath for the indexed sequential search: value table, index, live marks,
// walk and scan pointers, used-length register and result register. Uses iss_pkg.
`default_nettype none

module iss_dp #(
  parameter int VALUE_BITS    = iss_pkg::DEF_VALUE_BITS,
  parameter int INDEX_STRIDE  = iss_pkg::DEF_INDEX_STRIDE,
  parameter int INDEX_ENTRIES = iss_pkg::DEF_INDEX_ENTRIES
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire iss_pkg::cmd_t                 cmd,
  output iss_pkg::status_t                   st,
  input  wire logic [iss_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [iss_pkg::POS_W-1:0]     in_position,
  input  wire logic [iss_pkg::KEY_W-1:0]     in_value,
  input  wire logic                          cfg_we,
  input  wire logic [iss_pkg::PTR_W-1:0]     cfg_wdata,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_found,
  output logic [iss_pkg::POS_W-1:0]          out_found_position
);

  localparam int TL    = iss_pkg::TABLE_LENGTH;
  localparam int POS_W = iss_pkg::POS_W;
  localparam int PTR_W = iss_pkg::PTR_W;
  localparam int JW    = $clog2(INDEX_ENTRIES + 1);
  localparam int IAW   = (INDEX_ENTRIES > 1) ? $clog2(INDEX_ENTRIES) : 1;
  localparam int BLK_REACH = (TL + INDEX_STRIDE - 1) / INDEX_STRIDE;
  localparam int BLK_CNT   = (BLK_REACH < INDEX_ENTRIES) ? BLK_REACH : INDEX_ENTRIES;

  logic [VALUE_BITS-1:0] value_mem [TL];
  logic [VALUE_BITS-1:0] index_mem [INDEX_ENTRIES];
  logic [TL-1:0]         live_r;

  logic [PTR_W-1:0]          used_len_r;
  logic [iss_pkg::KIND_W-1:0] kind_r;
  logic [VALUE_BITS-1:0]     key_r;
  logic [PTR_W-1:0]          len_r;
  logic [POS_W-1:0]          lpos_r;
  logic [JW-1:0]             j_r, j_nxt;
  logic [PTR_W-1:0]          bstart_r;
  logic [PTR_W-1:0]          blk_r;
  logic                      have_r;
  logic [PTR_W-1:0]          pos_r, pos_nxt;
  logic                      hit_r;
  logic [POS_W-1:0]          hitpos_r;
  logic [VALUE_BITS-1:0]     ikey_q, sval_q;
  logic                      out_valid_r, out_found_r;
  logic [POS_W-1:0]          out_pos_r;

  logic                  load_wr;
  logic                  idx_wr;
  logic [IAW-1:0]        idx_wa;
  logic [VALUE_BITS-1:0] new_val;
  logic [PTR_W-1:0]      len_cap;
  logic                  cur_live;
  logic                  res_found;
  logic [POS_W-1:0]      res_pos;

  assign new_val = VALUE_BITS'(in_value);
  assign load_wr = cmd.start && (in_kind == iss_pkg::KIND_LOAD);
  assign len_cap = (used_len_r > PTR_W'(TL)) ? PTR_W'(TL) : used_len_r;
  assign cur_live = live_r[pos_r[POS_W-1:0]];

  // Block-start positions get an index key when loaded.
  always_comb begin
    idx_wr = 1'b0;
    idx_wa = '0;
    for (int k = 0; k < BLK_CNT; k++) begin
      if (int'(in_position) == k * INDEX_STRIDE) begin
        idx_wr = load_wr;
        idx_wa = IAW'(k);
      end
    end
  end

  always_comb begin
    j_nxt = j_r;
    if (cmd.start) begin
      j_nxt = '0;
    end else if (cmd.walk_adv) begin
      j_nxt = j_r + JW'(1);
    end
    pos_nxt = pos_r;
    if (cmd.scan_begin) begin
      pos_nxt = blk_r;
    end else if (cmd.scan_adv) begin
      pos_nxt = pos_r + PTR_W'(1);
    end
  end

  assign st.new_lookup = (in_kind == iss_pkg::KIND_SEARCH) ||
                         (in_kind == iss_pkg::KIND_REMOVE);
  assign st.walk_go    = (j_r < JW'(INDEX_ENTRIES)) && (bstart_r < len_r) &&
                         !(ikey_q > key_r);
  assign st.have_blk   = have_r;
  assign st.scan_go    = (pos_r < len_r) && !(cur_live && (sval_q > key_r));
  assign st.out_free   = !out_valid_r || out_ready;

  // Memories: one write port, registered read at the next pointer value.
  always_ff @(posedge clk) begin
    if (load_wr) begin
      value_mem[in_position] <= new_val;
    end
    if (idx_wr) begin
      index_mem[idx_wa] <= new_val;
    end
    ikey_q <= index_mem[j_nxt[IAW-1:0]];
    sval_q <= value_mem[pos_nxt[POS_W-1:0]];
  end

  always_ff @(posedge clk) begin
    j_r   <= j_nxt;
    pos_r <= pos_nxt;
    if (cmd.start) begin
      kind_r   <= in_kind;
      key_r    <= new_val;
      len_r    <= len_cap;
      lpos_r   <= in_position;
      bstart_r <= '0;
      have_r   <= 1'b0;
      hit_r    <= 1'b0;
    end
    if (cmd.walk_adv) begin
      blk_r    <= bstart_r;
      have_r   <= 1'b1;
      bstart_r <= bstart_r + PTR_W'(INDEX_STRIDE);
    end
    if (cmd.scan_adv && cur_live && (sval_q == key_r)) begin
      hit_r    <= 1'b1;
      hitpos_r <= pos_r[POS_W-1:0];
    end
    if (cmd.finish) begin
      out_found_r <= res_found;
      out_pos_r   <= res_pos;
    end
  end

  always_comb begin
    res_found = 1'b0;
    res_pos   = '0;
    case (kind_r)
      iss_pkg::KIND_LOAD: begin
        res_found = 1'b1;
        res_pos   = lpos_r;
      end
      iss_pkg::KIND_SEARCH, iss_pkg::KIND_REMOVE: begin
        res_found = hit_r;
        res_pos   = hit_r ? hitpos_r : '0;
      end
      default: begin
        res_found = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_len_r  <= PTR_W'(TL);
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        used_len_r <= cfg_wdata;
      end
      if (load_wr) begin
        live_r[in_position] <= 1'b1;
      end
      // drop the live mark of a removed entry
      if (cmd.finish && (kind_r == iss_pkg::KIND_REMOVE) && hit_r) begin
        live_r[hitpos_r] <= 1'b0;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_found_position = out_pos_r;

endmodule

`default_nettype wire

[tb/iss_search_checker.sv]
// Result checker for the indexed sequential search block: it watches both channels and
// the used-length port, predicts each result in order and compares it with the block.
// Depends on iss_pkg.
module iss_search_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [iss_pkg::KIND_W-1:0] in_kind,
  input  logic [iss_pkg::POS_W-1:0]  in_position,
  input  logic [iss_pkg::KEY_W-1:0]  in_value,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       out_found,
  input  logic [iss_pkg::POS_W-1:0]  out_found_position,
  input  logic                       cfg_we,
  input  logic [iss_pkg::PTR_W-1:0]  cfg_wdata,
  output int                         mismatches,
  output int                         answers_due,
  output int                         hits_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_LENGTH = iss_pkg::TABLE_LENGTH;
  localparam int POS_W        = iss_pkg::POS_W;
  localparam int PTR_W        = iss_pkg::PTR_W;
  localparam int KIND_W       = iss_pkg::KIND_W;
  localparam int KEY_W        = iss_pkg::KEY_W;
  localparam int STRIDE     = iss_pkg::DEF_INDEX_STRIDE;
  localparam int ENTRIES    = iss_pkg::DEF_INDEX_ENTRIES;
  localparam int PRINT_CAP  = 40;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] slot;
  } answer_t;

  logic [KEY_W-1:0] slot_value [TABLE_LENGTH];
  logic             slot_live  [TABLE_LENGTH];
  logic [KEY_W-1:0] block_key  [ENTRIES];
  logic [PTR_W-1:0] used_length;
  answer_t          expected_answers [$];
  int               results_seen;

  // Walk the index while its keys are not above the key, then scan forward
  // from the chosen block; keep the last live slot that holds the key.
  function automatic answer_t find_last_live(input logic [KEY_W-1:0] key);
    answer_t ans;
    int      span;
    int      first;
    bit      have_block;
    ans        = '0;
    span       = (used_length > TABLE_LENGTH) ? TABLE_LENGTH : int'(used_length);
    first      = 0;
    have_block = 1'b0;
    for (int j = 0; j < ENTRIES && j * STRIDE < span; j++) begin
      if (block_key[j] > key) break;
      first      = j * STRIDE;
      have_block = 1'b1;
    end
    if (have_block) begin
      for (int p = first; p < span; p++) begin
        if (!slot_live[p]) continue;
        if (slot_value[p] > key) break;
        if (slot_value[p] == key) begin
          ans.found = 1'b1;
          ans.slot  = POS_W'(p);
        end
      end
    end
    return ans;
  endfunction

  // Apply one item to the table copy and return the answer it should give.
  function automatic answer_t apply_item(input logic [KIND_W-1:0] kind,
                                         input logic [POS_W-1:0]  pos,
                                         input logic [KEY_W-1:0]  value);
    answer_t ans;
    ans = '0;
    case (kind)
      iss_pkg::KIND_LOAD: begin
        slot_value[pos] = value;
        slot_live[pos]  = 1'b1;
        if (pos % STRIDE == 0 && pos / STRIDE < ENTRIES) block_key[pos / STRIDE] = value;
        ans.found = 1'b1;
        ans.slot  = pos;
      end
      iss_pkg::KIND_SEARCH, iss_pkg::KIND_REMOVE: begin
        ans = find_last_live(value);
        if (ans.found) begin
          hits_seen++;
          if (kind == iss_pkg::KIND_REMOVE) slot_live[ans.slot] = 1'b0;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("%0t ns: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : watch
    answer_t want;
    if (!rst_n) begin
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      used_length = PTR_W'(TABLE_LENGTH);
      expected_answers.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_answers.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no item outstanding",
                                    results_seen));
        end else begin
          want = expected_answers.pop_front();
          if (out_found !== want.found)
            report_mismatch($sformatf("result %0d: found %0b, expected %0b",
                                      results_seen, out_found, want.found));
          if (out_found_position !== want.slot)
            report_mismatch($sformatf("result %0d: position %0d, expected %0d",
                                      results_seen, out_found_position, want.slot));
        end
      end
      if (in_valid && in_ready)
        expected_answers.push_back(apply_item(in_kind, in_position, in_value));
      if (cfg_we) used_length = cfg_wdata;
    end
    answers_due = expected_answers.size();
  end

endmodule

[tb/indexed_sequential_search_tb.sv]
// Top of the indexed sequential search testbench: clock, reset, stimulus, pacing
// and verdict. Depends on iss_pkg, indexed_sequential_search and iss_search_checker.
module indexed_sequential_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_LENGTH = iss_pkg::TABLE_LENGTH;
  localparam int POS_W        = iss_pkg::POS_W;
  localparam int PTR_W        = iss_pkg::PTR_W;
  localparam int KIND_W       = iss_pkg::KIND_W;
  localparam int KEY_W        = iss_pkg::KEY_W;

  localparam int HALF_PERIOD   = 5;
  localparam int ITEM_TARGET   = 1550;
  localparam int MAX_PAUSE     = 13;
  localparam int LONG_HOLD     = 400;   // receiver hold-off that backs the block up
  localparam int IDLE_LIMIT    = 3000;  // cycles with no handshake before giving up
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 200;   // longer than one full index walk plus scan

  // The package names three kinds; the fourth code is a do-nothing item.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef logic [KEY_W-1:0] key_t;

  // How one side paces its handshakes.
  typedef enum int {
    PACE_FLAT,     // never idle
    PACE_UNIFORM,  // 0..MAX_PAUSE cycles before every item
    PACE_SPARSE    // mostly back to back, an occasional pause
  } pace_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [KIND_W-1:0] in_kind     = iss_pkg::KIND_LOAD;
  logic [POS_W-1:0]  in_position = '0;
  logic [KEY_W-1:0]  in_value    = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic              out_found;
  logic [POS_W-1:0]  out_found_position;
  logic              cfg_we      = 1'b0;
  logic [PTR_W-1:0]  cfg_wdata   = '0;

  int    mismatches;
  int    answers_due;
  int    hits_seen;
  pace_t src_mode  = PACE_FLAT;
  pace_t sink_mode = PACE_FLAT;
  bit    long_hold_req;
  int    idle_cycles;
  int    n_loads, n_searches, n_removes, n_unused, n_length_writes;
  int    cur_length;

  // Values the stimulus has put in each slot; used only to aim keys at hits.
  key_t  loaded_values [TABLE_LENGTH];

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  indexed_sequential_search uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_found          (out_found),
    .out_found_position (out_found_position),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  iss_search_checker result_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_found          (out_found),
    .out_found_position (out_found_position),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .mismatches         (mismatches),
    .answers_due        (answers_due),
    .hits_seen          (hits_seen)
  );

  // Watchdog: count cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Stalled for %0d cycles with %0d results outstanding", idle_cycles,
               answers_due);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int draw_pause(input pace_t mode);
    case (mode)
      PACE_FLAT:    return 0;
      PACE_UNIFORM: return $urandom_range(0, MAX_PAUSE);
      default:      return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_PAUSE) : 0;
    endcase
  endfunction

  // Receiver: draw a wait per item, hold ready low for it, then take one item.
  // A pending long-hold request replaces the drawn wait once.
  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = draw_pause(sink_mode);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // Offer one item after the drawn gap and hold it until accepted. Valid
  // stays high across back-to-back items; it only drops for a real gap.
  task automatic offer_item(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                            input key_t value);
    int gap;
    gap = draw_pause(src_mode);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_position <= pos;
    in_value    <= value;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
    case (kind)
      iss_pkg::KIND_LOAD:   n_loads++;
      iss_pkg::KIND_SEARCH: n_searches++;
      iss_pkg::KIND_REMOVE: n_removes++;
      default:              n_unused++;
    endcase
  endtask

  // Stop offering and wait for every outstanding result; the block is idle after.
  task automatic drain_answers();
    in_valid <= 1'b0;
    wait (answers_due == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the used-length register; call only from a drained, idle block.
  task automatic write_used_length(input int length);
    cfg_we    <= 1'b1;
    cfg_wdata <= PTR_W'(length);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_length = length;
    n_length_writes++;
  endtask

  // Load all slots with a nondecreasing run. Narrow steps give long runs of
  // duplicates; wide steps sweep the key range and pile up at the top value.
  task automatic fill_table();
    int level;
    int step_max;
    int slot;
    bit downward;
    case ($urandom_range(0, 2))
      0:       step_max = 2;
      1:       step_max = 200;
      default: step_max = 700;
    endcase
    level = (step_max == 2) ? $urandom_range(0, 65000) : $urandom_range(0, 300);
    for (int p = 0; p < TABLE_LENGTH; p++) begin
      level += $urandom_range(0, step_max);
      if (level > 65535) level = 65535;
      loaded_values[p] = key_t'(level);
    end
    // The index is recorded per load, so the load order must not matter.
    downward = ($urandom_range(0, 3) == 0);
    for (int p = 0; p < TABLE_LENGTH; p++) begin
      slot = downward ? TABLE_LENGTH - 1 - p : p;
      offer_item(iss_pkg::KIND_LOAD, POS_W'(slot), loaded_values[slot]);
    end
  endtask

  // Reload one random slot: either between its neighbors, keeping the order
  // (and reviving a removed entry), or with any value as noise.
  task automatic load_one(input bit keep_order);
    int   slot;
    int   lo;
    int   hi;
    key_t value;
    slot = $urandom_range(0, TABLE_LENGTH - 1);
    if (keep_order) begin
      lo = (slot == 0) ? 0 : int'(loaded_values[slot - 1]);
      hi = (slot == TABLE_LENGTH - 1) ? 65535 : int'(loaded_values[slot + 1]);
      value = key_t'((lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(hi, lo));
    end else begin
      value = key_t'($urandom);
    end
    loaded_values[slot] = value;
    offer_item(iss_pkg::KIND_LOAD, POS_W'(slot), value);
  endtask

  // Aim mostly at values inside the used span, then near misses, keys below
  // the first block, arbitrary keys and the two extremes.
  function automatic key_t pick_key();
    int span;
    int slot;
    int roll;
    span = (cur_length > TABLE_LENGTH) ? TABLE_LENGTH : cur_length;
    slot = $urandom_range(0, (span > 0) ? span - 1 : 0);
    roll = $urandom_range(0, 99);
    if (roll < 60) return loaded_values[slot];
    if (roll < 68) return loaded_values[slot] + 16'd1;
    if (roll < 75) return loaded_values[slot] - 16'd1;
    if (roll < 85)
      return (loaded_values[0] == '0) ? '0 : key_t'($urandom_range(0, loaded_values[0] - 1));
    if (roll < 95) return key_t'($urandom);
    return (roll < 97) ? '0 : '1;
  endfunction

  // Mixed traffic: searches, removes, interleaved reloads and a few
  // unused-kind items. The position field is random where it is ignored.
  task automatic run_queries(input int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        offer_item(iss_pkg::KIND_SEARCH, POS_W'($urandom), pick_key());
      end else if (roll < 80) begin
        offer_item(iss_pkg::KIND_REMOVE, POS_W'($urandom), pick_key());
      end else if (roll < 95) begin
        load_one(roll < 90);
      end else begin
        offer_item(KIND_UNUSED, POS_W'($urandom), key_t'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    int round;
    int length;
    int roll;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Keep the used length inside the first block so the
    // index walk only reads the one index entry written so far.
    write_used_length(8);
    offer_item(iss_pkg::KIND_LOAD, 7'd0, 16'd10);
    offer_item(iss_pkg::KIND_LOAD, 7'd1, 16'd10);
    offer_item(iss_pkg::KIND_LOAD, 7'd2, 16'd11);
    offer_item(iss_pkg::KIND_LOAD, 7'd3, 16'd101);
    offer_item(iss_pkg::KIND_LOAD, 7'd4, 16'd101);
    offer_item(iss_pkg::KIND_LOAD, 7'd5, 16'd300);
    offer_item(iss_pkg::KIND_LOAD, 7'd6, 16'hFFFF);
    offer_item(iss_pkg::KIND_LOAD, 7'd7, 16'hFFFF);
    offer_item(iss_pkg::KIND_LOAD, 7'd127, 16'd0);        // top slot, outside the span
    offer_item(iss_pkg::KIND_SEARCH, 7'd127, 16'd0);      // below the first index key
    offer_item(iss_pkg::KIND_SEARCH, 7'd0, 16'd10);       // duplicate: last copy wins
    offer_item(iss_pkg::KIND_SEARCH, 7'd127, 16'd11);
    offer_item(iss_pkg::KIND_SEARCH, 7'd127, 16'd12);     // falls between two values
    offer_item(iss_pkg::KIND_SEARCH, 7'd127, 16'hFFFF);
    offer_item(iss_pkg::KIND_REMOVE, 7'd127, 16'd10);
    offer_item(iss_pkg::KIND_SEARCH, 7'd127, 16'd10);     // earlier copy still live
    offer_item(iss_pkg::KIND_REMOVE, 7'd127, 16'd10);
    offer_item(iss_pkg::KIND_SEARCH, 7'd127, 16'd10);     // every copy removed
    offer_item(iss_pkg::KIND_SEARCH, 7'd127, 16'd11);     // block head dead, index unchanged
    offer_item(iss_pkg::KIND_REMOVE, 7'd127, 16'hFFFF);
    offer_item(iss_pkg::KIND_SEARCH, 7'd127, 16'hFFFF);
    offer_item(iss_pkg::KIND_SEARCH, 7'd127, 16'd101);
    offer_item(KIND_UNUSED, 7'd127, 16'd11);
    drain_answers();
    write_used_length(0);                        // empty table: everything misses
    offer_item(iss_pkg::KIND_SEARCH, 7'd0, 16'd101);
    drain_answers();
    write_used_length(3);                        // scan stops at the used length
    offer_item(iss_pkg::KIND_SEARCH, 7'd0, 16'd11);
    offer_item(iss_pkg::KIND_SEARCH, 7'd0, 16'd101);
    drain_answers();

    // Random part. The first round loads every slot, which writes every
    // index entry before any walk can reach past the first block.
    round = 0;
    while (n_loads + n_searches + n_removes < ITEM_TARGET) begin
      src_mode  = pace_t'($urandom_range(0, 2));
      sink_mode = pace_t'($urandom_range(0, 2));
      if (round == 0 || $urandom_range(0, 3) == 0) begin
        fill_table();
      end else begin
        repeat ($urandom_range(1, 12)) load_one($urandom_range(0, 3) != 0);
      end
      // Pause the sender until the block has answered everything, then retune.
      drain_answers();
      case (round)
        0: length = TABLE_LENGTH;
        1: length = 1;
        2: length = 255;  // above the table size: acts as the full table
        3: length = 0;
        default: begin
          roll = $urandom_range(0, 9);
          if (roll < 5)      length = $urandom_range(64, TABLE_LENGTH);
          else if (roll < 7) length = TABLE_LENGTH;
          else if (roll < 9) length = $urandom_range(1, 24);
          else               length = $urandom_range(TABLE_LENGTH + 1, 255);
        end
      endcase
      write_used_length(length);
      // Back the block up now and then: the receiver holds off while the
      // sender keeps offering.
      if (round == 2 || $urandom_range(0, 7) == 0) long_hold_req = 1'b1;
      run_queries($urandom_range(40, 120));
      round++;
    end
    drain_answers();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d loads, %0d searches, %0d removes, %0d unused-kind items",
             n_loads, n_searches, n_removes, n_unused);
    $display("over %0d used-length settings; %0d lookups hit, %0d mismatches",
             n_length_writes, hits_seen, mismatches);
    if (mismatches == 0 && answers_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/iss_pkg.sv
rtl/iss_ctrl.sv
rtl/iss_dp.sv
rtl/indexed_sequential_search.sv
tb/iss_search_checker.sv
tb/indexed_sequential_search_tb.sv
